// ===== sv/qdc_unpk_pkg.sv =====
package qdc_unpk_pkg;

  localparam logic [31:0] ALL_ONES_WORD = 32'hffff_ffff;
  localparam logic [2:0]  KIND_DATA     = 3'd0;
  localparam logic [2:0]  KIND_TRAILER  = 3'd4;
  localparam int          PARAM_PORT_W  = 16;
  localparam int          QUEUE_DEPTH   = 2;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_DATA    = 2'd1,
    PH_TRAILER = 2'd2,
    PH_FILL    = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_CONSUMED   = 3'd0,
    ST_WRITE      = 3'd1,
    ST_ENDED      = 3'd2,
    ST_ENDED_KEPT = 3'd3,
    ST_FOREIGN    = 3'd4,
    ST_MAPPED     = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    OP_STATUS = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_MAPWR  = 2'd2
  } op_t;

  typedef struct packed {
    op_t                     op;
    status_t                 status;
    logic [5:0]              chan;
    logic                    mapped;
    logic [11:0]             value;
    logic [PARAM_PORT_W-1:0] param;
  } item_t;

endpackage

// ===== sv/qdc_readout_word_unpacker_core.sv =====
// Readout word unpacker for a peak-sensing ADC module.
// Input channel (in_valid / in_stall): one beat carries either a 32-bit
// readout word (in_cmd = 0) or a channel map write (in_cmd = 1).
// Output channel (out_valid / out_stall): exactly one result beat per input
// beat, in order: status, parameter index and 12-bit value.
// Config channel (cfg_valid / cfg_ready): geographic address of the module;
// cfg_ready is always high. Write it only while the block is idle.
// Throughput: one beat per cycle while out_stall is low. Each accepted input
// beat is written into the two-entry queue between the parser and the
// map lookup stage, whose memory read is registered into the output stage.
// When out_stall holds, the output beat is kept, the queue fills and then
// in_stall rises; nothing is dropped.
// Reset (rst_n low at a clock edge): parser waits for a header, every map
// entry reads as unmapped, the address register is 0, queue and output
// register are emptied.
module qdc_readout_word_unpacker_core #(
  parameter int PARAM_INDEX_BITS = 16,
  parameter int MAP_CHANNELS     = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic [31:0] in_readout_word,
  input  logic [5:0]  in_map_channel,
  input  logic        in_map_mapped,
  input  logic [15:0] in_map_param,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [15:0] out_param_index,
  output logic [11:0] out_adc_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data
);

  qdc_unpk_pkg::item_t front_item, q_head;
  logic                accept, q_full, q_empty, q_pop;

  assign cfg_ready = 1'b1;
  assign in_stall  = q_full;
  assign accept    = in_valid && !q_full;

  qdc_unpk_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .accept       (accept),
    .cmd          (in_cmd),
    .readout_word (in_readout_word),
    .map_channel  (in_map_channel),
    .map_mapped   (in_map_mapped),
    .map_param    (in_map_param),
    .item         (front_item)
  );

  qdc_unpk_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_data (front_item),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  qdc_unpk_back #(
    .PARAM_INDEX_BITS (PARAM_INDEX_BITS),
    .MAP_CHANNELS     (MAP_CHANNELS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (q_head),
    .empty           (q_empty),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_param_index (out_param_index),
    .out_adc_value   (out_adc_value)
  );

  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != qdc_unpk_pkg::ST_WRITE) |->
      (out_param_index == '0 && out_adc_value == '0))
    else $error("payload not cleared on a result without parameter write");

  a_stall_needs_blocked_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled while output stage is free");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && q_empty && (!out_valid || !out_stall)) |-> ##2 out_valid)
    else $error("result did not reach the output two cycles after accept");

endmodule

// ===== sv/qdc_unpk_front.sv =====
module qdc_unpk_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  input  logic [4:0]             cfg_data,
  input  logic                   accept,
  input  logic                   cmd,
  input  logic [31:0]            readout_word,
  input  logic [5:0]             map_channel,
  input  logic                   map_mapped,
  input  logic [15:0]            map_param,
  output qdc_unpk_pkg::item_t    item
);

  qdc_unpk_pkg::phase_t phase_r, phase_nxt;
  logic [4:0]           geo_r;
  logic [2:0]           kind;
  logic                 all_ones;
  qdc_unpk_pkg::status_t end_status;

  assign kind       = readout_word[26:24];
  assign all_ones   = (readout_word == qdc_unpk_pkg::ALL_ONES_WORD);
  assign end_status = all_ones ? qdc_unpk_pkg::ST_ENDED : qdc_unpk_pkg::ST_ENDED_KEPT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= qdc_unpk_pkg::PH_HEADER;
      geo_r   <= '0;
    end else begin
      if (accept) phase_r <= phase_nxt;
      if (cfg_valid) geo_r <= cfg_data;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    item.op     = qdc_unpk_pkg::OP_STATUS;
    item.status = qdc_unpk_pkg::ST_CONSUMED;
    item.chan   = readout_word[21:16];
    item.mapped = map_mapped;
    item.value  = readout_word[11:0];
    item.param  = map_param;
    if (cmd) begin
      item.op     = qdc_unpk_pkg::OP_MAPWR;
      item.status = qdc_unpk_pkg::ST_MAPPED;
      item.chan   = map_channel;
    end else begin
      unique case (phase_r)
        qdc_unpk_pkg::PH_HEADER: begin
          if (all_ones) begin
            item.status = qdc_unpk_pkg::ST_ENDED;
          end else if (readout_word[31:27] != geo_r) begin
            item.status = qdc_unpk_pkg::ST_FOREIGN;
          end else begin
            phase_nxt = (kind == qdc_unpk_pkg::KIND_TRAILER) ?
                        qdc_unpk_pkg::PH_FILL : qdc_unpk_pkg::PH_DATA;
          end
        end
        qdc_unpk_pkg::PH_DATA: begin
          if (kind == qdc_unpk_pkg::KIND_DATA) begin
            // drop overflow and underflow words here, look up the rest later
            if (readout_word[13:12] == 2'b00) item.op = qdc_unpk_pkg::OP_LOOKUP;
          end else if (kind == qdc_unpk_pkg::KIND_TRAILER) begin
            phase_nxt = qdc_unpk_pkg::PH_TRAILER;
          end else begin
            phase_nxt   = qdc_unpk_pkg::PH_HEADER;
            item.status = end_status;
          end
        end
        qdc_unpk_pkg::PH_TRAILER: begin
          if (kind != qdc_unpk_pkg::KIND_TRAILER) begin
            phase_nxt   = qdc_unpk_pkg::PH_HEADER;
            item.status = end_status;
          end
        end
        qdc_unpk_pkg::PH_FILL: begin
          phase_nxt   = qdc_unpk_pkg::PH_HEADER;
          item.status = end_status;
        end
        default: begin
          phase_nxt = qdc_unpk_pkg::PH_HEADER;
        end
      endcase
    end
  end

endmodule

// ===== sv/qdc_unpk_queue.sv =====
module qdc_unpk_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  qdc_unpk_pkg::item_t push_data,
  input  logic                pop,
  output qdc_unpk_pkg::item_t head,
  output logic                full,
  output logic                empty
);

  localparam int PTR_W = $clog2(qdc_unpk_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(qdc_unpk_pkg::QUEUE_DEPTH + 1);

  qdc_unpk_pkg::item_t slot_r [qdc_unpk_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]    count_r;

  assign full  = (count_r == CNT_W'(qdc_unpk_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ===== sv/qdc_unpk_back.sv =====
module qdc_unpk_back #(
  parameter int PARAM_INDEX_BITS = 16,
  parameter int MAP_CHANNELS     = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  qdc_unpk_pkg::item_t head,
  input  logic                empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          out_status,
  output logic [15:0]         out_param_index,
  output logic [11:0]         out_adc_value
);

  localparam int MAP_W = (PARAM_INDEX_BITS < qdc_unpk_pkg::PARAM_PORT_W) ?
                         PARAM_INDEX_BITS : qdc_unpk_pkg::PARAM_PORT_W;
  localparam int IDX_W = $clog2(MAP_CHANNELS);

  logic [MAP_W-1:0]        map_mem [MAP_CHANNELS];
  logic [MAP_CHANNELS-1:0] map_valid_r;
  logic [IDX_W-1:0]        idx;
  logic                    in_range;
  logic                    do_write, do_lookup;
  logic                    out_valid_r;
  logic                    hit_r;
  qdc_unpk_pkg::status_t   status_r;
  logic [11:0]             value_r;
  logic [MAP_W-1:0]        rd_r;

  assign idx       = head.chan[IDX_W-1:0];
  assign in_range  = ({1'b0, head.chan} < 7'(MAP_CHANNELS));
  assign pop       = !empty && (!out_valid_r || !out_stall);
  assign do_write  = pop && (head.op == qdc_unpk_pkg::OP_MAPWR) && in_range;
  assign do_lookup = pop && (head.op == qdc_unpk_pkg::OP_LOOKUP);

  always_ff @(posedge clk) begin
    if (do_write) map_mem[idx] <= head.param[MAP_W-1:0];
    if (do_lookup) rd_r <= map_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_valid_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (do_write) map_valid_r[idx] <= head.mapped;
      if (pop) out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      status_r <= head.status;
      value_r  <= head.value;
      hit_r    <= (head.op == qdc_unpk_pkg::OP_LOOKUP) && in_range && map_valid_r[idx];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = hit_r ? qdc_unpk_pkg::ST_WRITE : status_r;
  assign out_param_index = hit_r ? 16'(rd_r) : '0;
  assign out_adc_value   = hit_r ? value_r : '0;

endmodule
